// ===== rtl/srrx_pkg.sv =====
// srrx_pkg: shared types and constants for the selective-repeat receiver
// holds result kind codes, fixed port widths and controller/datapath structs
// no dependencies
package srrx_pkg;

    // fixed widths of the frame and result ports
    localparam int SEQ_PORT_W  = 3;
    localparam int DATA_PORT_W = 32;
    localparam int KIND_W      = 2;

    // result kind codes
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;   // take the frame on the input ports this cycle
        logic fetch;    // read the store at next expected
        logic deliver;  // emit one in-order frame and advance
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic drain_start;  // accepted frame lets at least one delivery follow
        logic drain_more;   // another delivery follows the current one
    } stat_t;

endpackage

// ===== rtl/selective_repeat_receiver.sv =====
// selective_repeat_receiver: top level of the selective-repeat ARQ receiver
// joins the srrx_ctrl state machine and the srrx_dp datapath
// depends on srrx_pkg, srrx_ctrl, srrx_dp
//
// A frame beat is taken when start is high and busy is low. The ACK or NAK
// appears on the result ports, marked by strobe, in the cycle after the beat.
// A bad frame, or a good frame that frees nothing for delivery, leaves busy
// low again in that same cycle, so such frames can be taken every cycle.
// When frames become deliverable, busy goes high and the fetch state reads the
// payload store, then one in-order frame is delivered per cycle until the run
// is done; the single read port of the payload store sets that pace. last
// marks the final result of each frame.
// Results are shown for one cycle only and the receiver cannot stall them.
// There is no clearing pass after reset.
module selective_repeat_receiver
#(
    parameter int SEQ_COUNT     = 8,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [srrx_pkg::SEQ_PORT_W-1:0]     seq_number,
    input  logic                                frame_bad,
    input  logic [srrx_pkg::DATA_PORT_W-1:0]    payload,
    output logic                                busy,
    output logic                                strobe,
    output logic [srrx_pkg::KIND_W-1:0]         kind,
    output logic [srrx_pkg::SEQ_PORT_W-1:0]     seq_out,
    output logic [srrx_pkg::DATA_PORT_W-1:0]    payload_out,
    output logic                                last
);

    srrx_pkg::cmd_t  cmd;
    srrx_pkg::stat_t stat;

    // sequencing
    srrx_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // storage and result path
    srrx_dp
    #(
        .SEQ_COUNT     (SEQ_COUNT),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seq_number  (seq_number),
        .frame_bad   (frame_bad),
        .payload     (payload),
        .stat        (stat),
        .strobe      (strobe),
        .kind        (kind),
        .seq_out     (seq_out),
        .payload_out (payload_out),
        .last        (last)
    );

endmodule

// ===== rtl/srrx_ctrl.sv =====
// srrx_ctrl: sequencing state machine of the selective-repeat receiver
// issues accept, fetch and deliver commands to srrx_dp
// depends on srrx_pkg
module srrx_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  srrx_pkg::stat_t stat,
    output logic           busy,
    output srrx_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_FETCH   = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and command decode
    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.fetch   = 1'b0;
        cmd.deliver = 1'b0;
        busy        = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.drain_start ? ST_FETCH : ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                cmd.deliver = 1'b1;
                state_next  = stat.drain_more ? ST_DELIVER : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/srrx_dp.sv =====
// srrx_dp: datapath of the selective-repeat receiver
// held marks, next expected pointer, payload store and result registers
// depends on srrx_pkg
module srrx_dp
#(
    parameter int SEQ_COUNT     = 8,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  srrx_pkg::cmd_t                      cmd,
    input  logic [srrx_pkg::SEQ_PORT_W-1:0]     seq_number,
    input  logic                                frame_bad,
    input  logic [srrx_pkg::DATA_PORT_W-1:0]    payload,
    output srrx_pkg::stat_t                     stat,
    output logic                                strobe,
    output logic [srrx_pkg::KIND_W-1:0]         kind,
    output logic [srrx_pkg::SEQ_PORT_W-1:0]     seq_out,
    output logic [srrx_pkg::DATA_PORT_W-1:0]    payload_out,
    output logic                                last
);

    localparam int SEQ_W  = (SEQ_COUNT > 2) ? $clog2(SEQ_COUNT) : 1;
    localparam int SPW    = srrx_pkg::SEQ_PORT_W;
    localparam int DPW    = srrx_pkg::DATA_PORT_W;
    localparam int NUM_IN = 2 ** SPW;

    logic [SEQ_W-1:0]         mod_tab [NUM_IN];
    logic [SEQ_W-1:0]         seq_in;
    logic [SEQ_COUNT-1:0]     one_hot_base;
    logic [SEQ_COUNT-1:0]     seq_bit;
    logic [SEQ_COUNT-1:0]     marks_acc;
    logic [SEQ_COUNT-1:0]     marks_clr;
    logic                     held;
    logic                     store_we;
    logic [SEQ_W-1:0]         nexp_inc;
    logic [PAYLOAD_WIDTH+DPW-1:0] wr_wide;
    logic [PAYLOAD_WIDTH-1:0] wr_data;
    logic [PAYLOAD_WIDTH+DPW-1:0] rd_wide;
    logic [SEQ_W+SPW-1:0]     seq_in_wide;
    logic [SEQ_W+SPW-1:0]     nexp_wide;

    logic [SEQ_COUNT-1:0]     marks_reg;
    logic [SEQ_COUNT-1:0]     marks_next;
    logic [SEQ_W-1:0]         nexp_reg;
    logic [SEQ_W-1:0]         nexp_next;
    logic [PAYLOAD_WIDTH-1:0] rd_data_reg;
    logic [PAYLOAD_WIDTH-1:0] store_mem [SEQ_COUNT];

    logic                     strobe_reg;
    logic                     strobe_next;
    logic [srrx_pkg::KIND_W-1:0] kind_reg;
    logic [srrx_pkg::KIND_W-1:0] kind_next;
    logic [SPW-1:0]           seq_out_reg;
    logic [SPW-1:0]           seq_out_next;
    logic [DPW-1:0]           payload_out_reg;
    logic [DPW-1:0]           payload_out_next;
    logic                     last_reg;
    logic                     last_next;

    // sequence number modulo the window size, as a small constant table
    for (genvar i = 0; i < NUM_IN; i++)
    begin : g_mod
        assign mod_tab[i] = SEQ_W'(i % SEQ_COUNT);
    end

    assign seq_in = mod_tab[seq_number];

    // mark updates for an accepted frame and for a delivery
    assign one_hot_base = {{(SEQ_COUNT-1){1'b0}}, 1'b1};
    assign seq_bit      = one_hot_base << seq_in;
    assign held         = marks_reg[seq_in];
    assign marks_acc    = frame_bad ? marks_reg : (marks_reg | seq_bit);
    assign marks_clr    = marks_reg & ~(one_hot_base << nexp_reg);
    assign nexp_inc     = (nexp_reg == SEQ_W'(SEQ_COUNT - 1)) ? '0 : nexp_reg + 1'b1;
    assign store_we     = cmd.accept && !frame_bad && !held;

    assign stat.drain_start = !frame_bad && marks_acc[nexp_reg];
    assign stat.drain_more  = marks_clr[nexp_inc];

    // payload kept to its low PAYLOAD_WIDTH bits, widened back to the port
    assign wr_wide     = {{PAYLOAD_WIDTH{1'b0}}, payload};
    assign wr_data     = wr_wide[PAYLOAD_WIDTH-1:0];
    assign rd_wide     = {{DPW{1'b0}}, rd_data_reg};
    assign seq_in_wide = {{SPW{1'b0}}, seq_in};
    assign nexp_wide   = {{SPW{1'b0}}, nexp_reg};

    // control state next values
    always_comb
    begin
        marks_next = marks_reg;
        nexp_next  = nexp_reg;
        if (cmd.accept)
            marks_next = marks_acc;
        else if (cmd.deliver)
        begin
            marks_next = marks_clr;
            nexp_next  = nexp_inc;
        end
    end

    // result register next values
    always_comb
    begin
        strobe_next      = cmd.accept || cmd.deliver;
        kind_next        = kind_reg;
        seq_out_next     = seq_out_reg;
        payload_out_next = payload_out_reg;
        last_next        = last_reg;
        if (cmd.accept)
        begin
            kind_next        = frame_bad ? srrx_pkg::KIND_NAK : srrx_pkg::KIND_ACK;
            seq_out_next     = seq_in_wide[SPW-1:0];
            payload_out_next = '0;
            last_next        = !stat.drain_start;
        end
        else if (cmd.deliver)
        begin
            kind_next        = srrx_pkg::KIND_DELIVER;
            seq_out_next     = nexp_wide[SPW-1:0];
            payload_out_next = rd_wide[DPW-1:0];
            last_next        = !stat.drain_more;
        end
    end

    // marks, pointer and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg  <= '0;
            nexp_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            marks_reg  <= marks_next;
            nexp_reg   <= nexp_next;
            strobe_reg <= strobe_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        seq_out_reg     <= seq_out_next;
        payload_out_reg <= payload_out_next;
        last_reg        <= last_next;
    end

    // payload store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[seq_in] <= wr_data;
        if (cmd.fetch)
            rd_data_reg <= store_mem[nexp_reg];
        else if (cmd.deliver)
            rd_data_reg <= store_mem[nexp_inc];
    end

    assign strobe      = strobe_reg;
    assign kind        = kind_reg;
    assign seq_out     = seq_out_reg;
    assign payload_out = payload_out_reg;
    assign last        = last_reg;

endmodule

// ===== tb/srrx_checker.sv =====
// srrx_checker: watches the frame and result channels of the selective-repeat receiver,
// predicts every ACK, NAK and in-order delivery and compares them field by field
// depends on srrx_pkg
module srrx_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [srrx_pkg::SEQ_PORT_W-1:0]  seq_number,
    input  logic                             frame_bad,
    input  logic [srrx_pkg::DATA_PORT_W-1:0] payload,
    input  logic                             strobe,
    input  logic [srrx_pkg::KIND_W-1:0]      kind,
    input  logic [srrx_pkg::SEQ_PORT_W-1:0]  seq_out,
    input  logic [srrx_pkg::DATA_PORT_W-1:0] payload_out,
    input  logic                             last,
    output int                               fail_count,
    output int                               pending,
    output int                               frames_seen,
    output int                               naks_seen,
    output int                               deliveries_seen,
    output int                               longest_drain
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW = 8;
    localparam int QDEPTH = 64;

    typedef struct packed {
        logic [srrx_pkg::KIND_W-1:0]      kind;
        logic [srrx_pkg::SEQ_PORT_W-1:0]  seq;
        logic [srrx_pkg::DATA_PORT_W-1:0] data;
        logic                             last;
    } rx_result_t;

    // receiver state as predicted
    logic [WINDOW-1:0]                held;
    logic [srrx_pkg::DATA_PORT_W-1:0] frame_store [WINDOW];
    logic [srrx_pkg::SEQ_PORT_W-1:0]  next_seq;

    // expected result beats, oldest at exp_rd
    rx_result_t exp_mem [QDEPTH];
    int         exp_wr;
    int         exp_rd;
    int         exp_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // append one expected result beat
    task automatic queue_expect(input logic [srrx_pkg::KIND_W-1:0]      kd,
                                input logic [srrx_pkg::SEQ_PORT_W-1:0]  sq,
                                input logic [srrx_pkg::DATA_PORT_W-1:0] dt,
                                input logic                             lst);
        rx_result_t r;
        r.kind = kd;
        r.seq  = sq;
        r.data = dt;
        r.last = lst;
        if (exp_count == QDEPTH)
            report_mismatch("expectation overflow, depth", exp_count, QDEPTH);
        else
        begin
            exp_mem[exp_wr] = r;
            exp_wr          = (exp_wr + 1) % QDEPTH;
            exp_count++;
        end
    endtask

    // work out the replies and deliveries one frame beat causes
    task automatic predict_frame(input logic [srrx_pkg::SEQ_PORT_W-1:0] s,
                                 input logic bad,
                                 input logic [srrx_pkg::DATA_PORT_W-1:0] d);
        int                              run;
        int                              k;
        logic [srrx_pkg::SEQ_PORT_W-1:0] idx;
        frames_seen++;
        if (bad)
        begin
            naks_seen++;
            queue_expect(srrx_pkg::KIND_NAK, s, '0, 1'b1);
        end
        else
        begin
            // a number already held keeps its first payload
            if (!held[s])
            begin
                frame_store[s] = d;
                held[s]        = 1'b1;
            end
            // length of the consecutive run from the next expected number
            run = 0;
            idx = next_seq;
            while (held[idx] && run < WINDOW)
            begin
                run++;
                idx++;
            end
            queue_expect(srrx_pkg::KIND_ACK, s, '0, run == 0);
            for (k = 0; k < run; k++)
            begin
                queue_expect(srrx_pkg::KIND_DELIVER, next_seq, frame_store[next_seq],
                             k == run - 1);
                held[next_seq] = 1'b0;
                next_seq       = next_seq + 1'b1;
            end
            deliveries_seen += run;
            if (run > longest_drain)
                longest_drain = run;
        end
    endtask

    // compare one result beat against the oldest expectation
    task automatic check_result();
        rx_result_t want;
        if (exp_count == 0)
            report_mismatch("result with nothing pending, seq", 32'(seq_out), '0);
        else
        begin
            want   = exp_mem[exp_rd];
            exp_rd = (exp_rd + 1) % QDEPTH;
            exp_count--;
            if (kind !== want.kind)
                report_mismatch("kind", 32'(kind), 32'(want.kind));
            if (seq_out !== want.seq)
                report_mismatch("seq_out", 32'(seq_out), 32'(want.seq));
            if (payload_out !== want.data)
                report_mismatch("payload_out", payload_out, want.data);
            if (last !== want.last)
                report_mismatch("last", 32'(last), 32'(want.last));
        end
    endtask

    // results are checked before the new beat is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held            = '0;
            next_seq        = '0;
            exp_wr          = 0;
            exp_rd          = 0;
            exp_count       = 0;
            fail_count      = 0;
            frames_seen     = 0;
            naks_seen       = 0;
            deliveries_seen = 0;
            longest_drain   = 0;
            pending <= 0;
        end
        else
        begin
            if (strobe)
                check_result();
            if (start && !busy)
                predict_frame(seq_number, frame_bad, payload);
            pending <= exp_count;
        end
    end

endmodule

// ===== tb/tb_selective_repeat_receiver.sv =====
// tb_selective_repeat_receiver: stimulus and verdict for the selective-repeat receiver
// drives frame beats with random gaps; checking is done by srrx_checker
// depends on srrx_pkg, srrx_checker, selective_repeat_receiver
module tb_selective_repeat_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_PORT_W  = srrx_pkg::SEQ_PORT_W;
    localparam int DATA_PORT_W = srrx_pkg::DATA_PORT_W;
    localparam int KIND_W      = srrx_pkg::KIND_W;

    localparam int RANDOM_FRAMES = 470;
    localparam int PAUSE_AT      = 250;
    localparam int DRAIN_CYCLES  = 12;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   start      = 1'b0;
    logic [SEQ_PORT_W-1:0]  seq_number = '0;
    logic                   frame_bad  = 1'b0;
    logic [DATA_PORT_W-1:0] payload    = '0;
    logic                   busy;
    logic                   strobe;
    logic [KIND_W-1:0]      kind;
    logic [SEQ_PORT_W-1:0]  seq_out;
    logic [DATA_PORT_W-1:0] payload_out;
    logic                   last;

    int fail_count;
    int pending;
    int frames_seen;
    int naks_seen;
    int deliveries_seen;
    int longest_drain;

    int                    frames_sent = 0;
    logic                  quiet       = 1'b0;
    logic [SEQ_PORT_W-1:0] tx_base     = '0;

    selective_repeat_receiver u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .seq_number  (seq_number),
        .frame_bad   (frame_bad),
        .payload     (payload),
        .busy        (busy),
        .strobe      (strobe),
        .kind        (kind),
        .seq_out     (seq_out),
        .payload_out (payload_out),
        .last        (last)
    );

    srrx_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .seq_number      (seq_number),
        .frame_bad       (frame_bad),
        .payload         (payload),
        .strobe          (strobe),
        .kind            (kind),
        .seq_out         (seq_out),
        .payload_out     (payload_out),
        .last            (last),
        .fail_count      (fail_count),
        .pending         (pending),
        .frames_seen     (frames_seen),
        .naks_seen       (naks_seen),
        .deliveries_seen (deliveries_seen),
        .longest_drain   (longest_drain)
    );

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("timeout: results still outstanding");
        $display("RESULT: ERROR");
        $finish;
    end

    // payload words lean on the extremes now and then
    function automatic logic [DATA_PORT_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drop start and hold garbage on the frame ports for a while
    task automatic idle(input int cycles);
        if (cycles > 0)
        begin
            start      <= 1'b0;
            seq_number <= SEQ_PORT_W'($urandom);
            frame_bad  <= 1'($urandom);
            payload    <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // one frame beat, then a random gap
    task automatic offer_frame(input logic [SEQ_PORT_W-1:0] s, input logic bad,
                               input logic [DATA_PORT_W-1:0] d);
        start      <= 1'b1;
        seq_number <= s;
        frame_bad  <= bad;
        payload    <= d;
        do
            @(posedge clk);
        while (busy);
        frames_sent++;
        idle(pick_gap());
    endtask

    // hold off until every predicted result has come out
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // a window of consecutive numbers in shuffled order, with some corrupted
    // copies ahead of the good one and some duplicate retransmissions
    task automatic send_window();
        logic [SEQ_PORT_W-1:0] order [8];
        logic [SEQ_PORT_W-1:0] t;
        int                    n;
        int                    j;
        int                    k;
        n     = $urandom_range(1, 8);
        quiet = ($urandom_range(0, 3) == 0);
        for (k = 0; k < n; k++)
            order[k] = tx_base + SEQ_PORT_W'(k);
        for (k = n - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            t        = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                offer_frame(order[k], 1'b1, rand_word());
            offer_frame(order[k], 1'b0, rand_word());
            if ($urandom_range(0, 9) == 0)
                offer_frame(order[k], 1'b0, rand_word());
        end
        tx_base = tx_base + SEQ_PORT_W'(n);
    endtask

    initial
    begin
        int  target;
        logic paused;
        paused = 1'b0;

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refused frame, plain in-order frame, out-of-order fill
        offer_frame(3'd0, 1'b1, 32'hFFFF_FFFF);
        offer_frame(3'd0, 1'b0, 32'hFFFF_FFFF);
        offer_frame(3'd2, 1'b0, 32'h0000_0000);
        offer_frame(3'd3, 1'b0, 32'h8000_0001);
        offer_frame(3'd1, 1'b0, 32'h1234_5678);
        // duplicate keeps the first payload; refused frame then its repeat
        offer_frame(3'd5, 1'b0, 32'hA5A5_A5A5);
        offer_frame(3'd5, 1'b0, 32'h5A5A_5A5A);
        offer_frame(3'd4, 1'b1, 32'hDEAD_BEEF);
        offer_frame(3'd4, 1'b0, 32'h0F0F_0F0F);
        // number behind the window, then fill all but the next expected one
        offer_frame(3'd2, 1'b0, 32'hCAFE_0002);
        offer_frame(3'd7, 1'b0, 32'h7777_7777);
        offer_frame(3'd0, 1'b0, 32'h0000_0010);
        offer_frame(3'd1, 1'b0, 32'h0000_0011);
        offer_frame(3'd3, 1'b0, 32'hFFFF_0003);
        offer_frame(3'd4, 1'b0, 32'h4444_4444);
        offer_frame(3'd5, 1'b0, 32'h5555_5555);
        // completes the window: ACK plus eight deliveries
        offer_frame(3'd6, 1'b0, 32'h6666_6666);
        offer_frame(3'd7, 1'b1, 32'h0000_0000);
        wait_drained();
        tx_base = 3'd6;

        // random: mostly well-formed windows, some stray frames
        target = frames_sent + RANDOM_FRAMES;
        while (frames_sent < target)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                quiet = 1'b0;
                offer_frame(SEQ_PORT_W'($urandom), $urandom_range(0, 3) == 0, rand_word());
            end
            else
                send_window();
            if (!paused && frames_sent > PAUSE_AT)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // drain and verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d frame beats, %0d refused, %0d frames delivered in order",
                 frames_seen, naks_seen, deliveries_seen);
        $display("longest in-order drain from one frame: %0d", longest_drain);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srrx_pkg.sv
rtl/srrx_ctrl.sv
rtl/srrx_dp.sv
rtl/selective_repeat_receiver.sv
tb/srrx_checker.sv
tb/tb_selective_repeat_receiver.sv
